FILE: hw/rtl/typed_integer_alu_unit_defines.svh
// Assertion macros for the typed integer ALU
`ifndef TYPED_INTEGER_ALU_UNIT_DEFINES_SVH
`define TYPED_INTEGER_ALU_UNIT_DEFINES_SVH

// immediate implication checked every cycle outside reset
`define TIA_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define TIA_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Shared types and codes for the typed integer ALU.
// ----------------------------------------------------------------------------
package tia_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned CntW  = 7;

    localparam logic [4:0] ACT_ADD = 5'd0, ACT_SUB = 5'd1, ACT_MUL = 5'd2,
        ACT_DIV = 5'd3, ACT_MOD = 5'd4, ACT_POW = 5'd5, ACT_AND = 5'd6,
        ACT_OR = 5'd7, ACT_XOR = 5'd8, ACT_SHL = 5'd9, ACT_SHR = 5'd10,
        ACT_EQ = 5'd11, ACT_NE = 5'd12, ACT_LT = 5'd13, ACT_LE = 5'd14,
        ACT_GT = 5'd15, ACT_GE = 5'd16, ACT_NEG = 5'd17, ACT_BNOT = 5'd18,
        ACT_LNOT = 5'd19, ACT_CAST = 5'd20;

    localparam logic [1:0] ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_SHIFT = 2'd2;
    localparam logic [1:0] KIND_BOOL = 2'd0, KIND_SIGNED = 2'd1;

    // request from control to the iterative unit
    typedef struct packed {
        logic       start;
        logic       is_mul;   // 0: divide, 1: multiply
    } tia_iter_req_t;

    // width masking and sign extension
    function automatic logic [DataW-1:0] fit_type(input logic [DataW-1:0] v,
                                                  input logic [1:0] kind,
                                                  input logic [1:0] wcode);
        logic [DataW-1:0] r;
        r = v;
        case (wcode)
            2'd0: r = (kind == KIND_SIGNED) ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
            2'd1: r = (kind == KIND_SIGNED) ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            2'd2: r = (kind == KIND_SIGNED) ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction
endpackage

FILE: hw/rtl/tia_iter.sv
// ----------------------------------------------------------------------------
// tia_iter
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
module tia_iter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tia_pkg::tia_iter_req_t    req,
    input  logic [tia_pkg::DataW-1:0] op_x,
    input  logic [tia_pkg::DataW-1:0] op_y,
    output logic                      busy,
    output logic                      done,
    output logic [tia_pkg::DataW-1:0] prod_quot,
    output logic [tia_pkg::DataW-1:0] rem
);
    import tia_pkg::*;

    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next, mul_reg, mul_next;
    logic [DataW-1:0] x_reg, x_next, y_reg, y_next, acc_reg, acc_next, r_reg, r_next;
    logic [DataW+1:0] trial;
    logic [DataW:0]   rsh;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mul_next  = mul_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        r_next    = r_reg;
        // partial remainder can reach 65 bits for large unsigned divisors
        rsh       = {r_reg, x_reg[DataW-1]};
        trial     = {1'b0, rsh} - {2'b00, y_reg};
        if (req.start) begin
            busy_next = 1'b1;
            mul_next  = req.is_mul;
            cnt_next  = '0;
            x_next    = op_x;
            y_next    = op_y;
            acc_next  = '0;
            r_next    = '0;
        end else if (busy_reg) begin
            if (mul_reg) begin
                // multiplier bits consumed lsb first, multiplicand doubles
                if (y_reg[0]) acc_next = acc_reg + x_reg;
                x_next = {x_reg[DataW-2:0], 1'b0};
                y_next = {1'b0, y_reg[DataW-1:1]};
            end else begin
                // restoring division, quotient bits shift into x
                if (!trial[DataW+1]) begin
                    r_next = trial[DataW-1:0];
                    x_next = {x_reg[DataW-2:0], 1'b1};
                end else begin
                    r_next = rsh[DataW-1:0];
                    x_next = {x_reg[DataW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DataW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mul_reg <= mul_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        r_reg   <= r_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign prod_quot = mul_reg ? acc_reg : x_reg;
    assign rem       = r_reg;
endmodule

FILE: hw/rtl/typed_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// typed_integer_alu_unit
// 64-bit integer ALU with typed, width-masked results.
// ----------------------------------------------------------------------------
// Single-cycle ops (add, logic, shifts, compares, unary, cast) compute in the
// execute state and return a registered word. Mul, div and mod run on the
// shared bit-serial unit, with setup and sign fix around it. Pow runs one
// multiply per set exponent bit and one squaring per further bit: up to 63
// multiplies and 62 squarings. One word at a time; s_axis_tready is low
// while a word is in work or waits on the output.
module typed_integer_alu_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] action, [68:5] operand_a, [132:69] operand_b,
    // [133] operand_signed, [135:134] result_kind, [137:136] result_width
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] result_value, [65:64] status
    output logic [71:0]  m_axis_tdata
);
    import tia_pkg::*;
    `include "typed_integer_alu_unit_defines.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_WAIT = 6'b000100,
        S_POWM = 6'b001000, S_POWS = 6'b010000, S_OUT = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       act_reg;
    logic [DataW-1:0] a_reg, b_reg, base_reg, base_next, ex_reg, ex_next;
    logic [DataW-1:0] acc_reg, acc_next, res_reg, res_next;
    logic             sg_reg;
    logic [1:0]       kind_reg, wcode_reg, st_reg, st_next;
    logic             ld;

    tia_iter_req_t    req;
    logic [DataW-1:0] it_x, it_y, it_q, it_r;
    logic             it_busy, it_done;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign ld = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (ld) begin
            act_reg   <= s_axis_tdata[4:0];
            a_reg     <= s_axis_tdata[68:5];
            b_reg     <= s_axis_tdata[132:69];
            sg_reg    <= s_axis_tdata[133];
            kind_reg  <= s_axis_tdata[135:134];
            wcode_reg <= s_axis_tdata[137:136];
        end
    end

    logic [DataW-1:0] ma, mb, smin;
    logic             neg_q, neg_r, slt_ab, slt_ba, ult_ab, ult_ba;
    assign smin  = {1'b1, {(DataW-1){1'b0}}};
    assign ma    = (sg_reg && a_reg[DataW-1]) ? -a_reg : a_reg;
    assign mb    = (sg_reg && b_reg[DataW-1]) ? -b_reg : b_reg;
    assign neg_q = sg_reg && (a_reg[DataW-1] ^ b_reg[DataW-1]);
    assign neg_r = sg_reg && a_reg[DataW-1];
    assign ult_ab = a_reg < b_reg;
    assign ult_ba = b_reg < a_reg;
    assign slt_ab = (a_reg ^ smin) < (b_reg ^ smin);
    assign slt_ba = (b_reg ^ smin) < (a_reg ^ smin);

    logic [DataW-1:0] shr_v, sra_v;
    assign shr_v = a_reg >> b_reg[5:0];
    assign sra_v = $signed(a_reg) >>> b_reg[5:0];

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        ex_next    = ex_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        req        = '0;
        it_x       = ma;
        it_y       = mb;
        case (state_reg)
            S_IDLE: begin
                if (ld) state_next = S_EXEC;
            end
            S_EXEC: begin
                st_next    = ST_OK;
                state_next = S_OUT;
                res_next   = '0;
                case (act_reg)
                    ACT_ADD: res_next = a_reg + b_reg;
                    ACT_SUB: res_next = a_reg - b_reg;
                    ACT_MUL: begin
                        req.start = 1'b1; req.is_mul = 1'b1;
                        it_x = a_reg; it_y = b_reg;
                        state_next = S_WAIT;
                    end
                    ACT_DIV, ACT_MOD: begin
                        if (b_reg == '0) st_next = ST_DIV0;
                        else begin
                            req.start = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    ACT_POW: begin
                        base_next = a_reg;
                        ex_next   = b_reg;
                        acc_next  = {{(DataW-1){1'b0}}, 1'b1};
                        if (b_reg[DataW-1]) res_next = '0;
                        else if (b_reg == '0) res_next = acc_next;
                        else if (b_reg[0]) begin
                            req.start = 1'b1; req.is_mul = 1'b1;
                            it_x = {{(DataW-1){1'b0}}, 1'b1}; it_y = a_reg;
                            state_next = S_POWM;
                        end else begin
                            req.start = 1'b1; req.is_mul = 1'b1;
                            it_x = a_reg; it_y = a_reg;
                            state_next = S_POWS;
                        end
                    end
                    ACT_AND: res_next = a_reg & b_reg;
                    ACT_OR:  res_next = a_reg | b_reg;
                    ACT_XOR: res_next = a_reg ^ b_reg;
                    ACT_SHL: begin
                        if (b_reg[DataW-1:6] != '0) st_next = ST_SHIFT;
                        else res_next = a_reg << b_reg[5:0];
                    end
                    ACT_SHR: begin
                        if (b_reg[DataW-1:6] != '0) st_next = ST_SHIFT;
                        else res_next = sg_reg ? sra_v : shr_v;
                    end
                    ACT_EQ: res_next = DataW'(a_reg == b_reg);
                    ACT_NE: res_next = DataW'(a_reg != b_reg);
                    ACT_LT: res_next = DataW'(sg_reg ? slt_ab : ult_ab);
                    ACT_LE: res_next = DataW'(sg_reg ? !slt_ba : !ult_ba);
                    ACT_GT: res_next = DataW'(sg_reg ? slt_ba : ult_ba);
                    ACT_GE: res_next = DataW'(sg_reg ? !slt_ab : !ult_ab);
                    ACT_NEG:  res_next = -a_reg;
                    ACT_BNOT: res_next = ~a_reg;
                    ACT_LNOT: res_next = DataW'(a_reg == '0);
                    ACT_CAST: res_next = (kind_reg == KIND_BOOL) ?
                                         DataW'(a_reg != '0) : a_reg;
                    default: res_next = '0;
                endcase
                if (state_next == S_OUT && st_next == ST_OK && act_reg <= ACT_CAST)
                    res_next = fit_type(res_next, kind_reg, wcode_reg);
            end
            S_WAIT: begin
                if (it_done) begin
                    case (act_reg)
                        ACT_MUL: res_next = it_q;
                        ACT_DIV: res_next = neg_q ? -it_q : it_q;
                        default: res_next = neg_r ? -it_r : it_r;
                    endcase
                    res_next   = fit_type(res_next, kind_reg, wcode_reg);
                    state_next = S_OUT;
                end
            end
            S_POWM: begin
                // acc *= base done for the low exponent bit; square base
                // unless no higher bits remain
                if (it_done) begin
                    acc_next = it_q;
                    if (ex_reg[DataW-1:1] == '0) begin
                        res_next   = fit_type(it_q, kind_reg, wcode_reg);
                        state_next = S_OUT;
                    end else begin
                        req.start = 1'b1; req.is_mul = 1'b1;
                        it_x = base_reg; it_y = base_reg;
                        state_next = S_POWS;
                    end
                end
            end
            S_POWS: begin
                // squared base now pairs with the next exponent bit
                if (it_done) begin
                    base_next = it_q;
                    ex_next   = {1'b0, ex_reg[DataW-1:1]};
                    if (ex_next[0]) begin
                        req.start = 1'b1; req.is_mul = 1'b1;
                        it_x = acc_reg; it_y = it_q;
                        state_next = S_POWM;
                    end else begin
                        req.start = 1'b1; req.is_mul = 1'b1;
                        it_x = it_q; it_y = it_q;
                        state_next = S_POWS;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
        base_reg <= base_next;
        ex_reg   <= ex_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

    tia_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .op_x      (it_x),
        .op_y      (it_y),
        .busy      (it_busy),
        .done      (it_done),
        .prod_quot (it_q),
        .rem       (it_r)
    );

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {6'd0, st_reg, res_reg};

    `TIA_ASSERT_IMP(a_ready_idle, aclk, aresetn, it_busy, !s_axis_tready)
    `TIA_ASSERT_IMP(a_err_zero, aclk, aresetn, m_axis_tvalid && st_reg != ST_OK,
                    res_reg == '0)
    `TIA_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid)
endmodule
